@@ hw/rtl/sha1_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 hash engine.
package sha1_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned CV_WORDS    = 5;
	localparam int unsigned BLK_WORDS   = 16;
	localparam int unsigned BLK_BYTES   = 64;
	localparam int unsigned LEN_OFFSET  = 56;

	localparam logic [6:0]  LAST_ROUND  = 7'd79;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;
	localparam logic [2:0]  MAX_BYTES   = 3'd4;

	localparam word_t K_CH  = 32'h5A827999;
	localparam word_t K_PA1 = 32'h6ED9EBA1;
	localparam word_t K_MAJ = 32'h8F1BBCDC;
	localparam word_t K_PA2 = 32'hCA62C1D6;

	localparam word_t SHA_IV [CV_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INS_IN,
		OP_INS_REST,
		OP_PAD,
		OP_LEN,
		OP_LEN_ZERO,
		OP_INIT,
		OP_ROUND,
		OP_ADD,
		OP_FINAL
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REST,
		ST_PAD,
		ST_LEN,
		ST_LEN_ZERO,
		ST_CINIT,
		ST_ROUND,
		ST_CADD,
		ST_OUT
	} state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [6:0] rnd;
	} dp_cmd_t;

	typedef struct packed {
		logic in_fill;
		logic in_last;
		logic last;
		logic pad_wrap;
		logic out_free;
	} dp_stat_t;

	function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
			input word_t c, input word_t d);
		word_t f;
		case (rnd) inside
			[7'd0:7'd19]:  f = (b & c) | (~b & d);
			[7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
			default:       f = b ^ c ^ d;
		endcase
		return f;
	endfunction

	function automatic word_t round_k(input logic [6:0] rnd);
		word_t k;
		case (rnd) inside
			[7'd0:7'd19]:  k = K_CH;
			[7'd20:7'd39]: k = K_PA1;
			[7'd40:7'd59]: k = K_MAJ;
			default:       k = K_PA2;
		endcase
		return k;
	endfunction

endpackage

@@ hw/rtl/sha1_ctrl.sv @@
// Sequencer for byte insertion, padding, compression rounds and digest release.
module sha1_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sha1_pkg::dp_stat_t stat,
	output sha1_pkg::dp_cmd_t  cmd
);
	import sha1_pkg::*;

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	logic [6:0] rnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 7'd1;
			end else begin
				rnd_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (stat.in_fill) begin
						state_d = ST_CINIT;
						ret_d   = ST_REST;
					end else if (stat.in_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_REST:     state_d = stat.last ? ST_PAD : ST_IDLE;
			ST_PAD: begin
				if (stat.pad_wrap) begin
					state_d = ST_CINIT;
					ret_d   = ST_LEN_ZERO;
				end else begin
					state_d = ST_LEN;
				end
			end
			ST_LEN, ST_LEN_ZERO: begin
				state_d = ST_CINIT;
				ret_d   = ST_OUT;
			end
			ST_CINIT:    state_d = ST_ROUND;
			ST_ROUND:    state_d = (rnd_q == LAST_ROUND) ? ST_CADD : ST_ROUND;
			ST_CADD:     state_d = ret_q;
			ST_OUT:      state_d = stat.out_free ? ST_IDLE : ST_OUT;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		cmd.rnd  = rnd_q;
		case (state_q)
			ST_IDLE:     cmd.op = in_valid ? OP_INS_IN : OP_NONE;
			ST_REST:     cmd.op = OP_INS_REST;
			ST_PAD:      cmd.op = OP_PAD;
			ST_LEN:      cmd.op = OP_LEN;
			ST_LEN_ZERO: cmd.op = OP_LEN_ZERO;
			ST_CINIT:    cmd.op = OP_INIT;
			ST_ROUND:    cmd.op = OP_ROUND;
			ST_CADD:     cmd.op = OP_ADD;
			ST_OUT:      cmd.op = stat.out_free ? OP_FINAL : OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == LAST_ROUND) |=> (state_q == ST_CADD))
		else $error("compression did not end after the last round");

	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CINIT) |=> (state_q == ST_ROUND && rnd_q == 7'd0))
		else $error("rounds did not start from zero");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= LAST_ROUND))
		else $error("round counter overran");

endmodule

@@ hw/rtl/sha1_dp.sv @@
// Datapath: block buffer, byte counter, round registers, chaining value and digest register.
module sha1_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1_pkg::dp_cmd_t  cmd,
	output sha1_pkg::dp_stat_t stat,
	input  logic [31:0]        data_word,
	input  logic [2:0]         valid_bytes,
	input  logic               last_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        digest_h0,
	output logic [31:0]        digest_h1,
	output logic [31:0]        digest_h2,
	output logic [31:0]        digest_h3,
	output logic [31:0]        digest_h4
);
	import sha1_pkg::*;

	function automatic logic [7:0] pick_byte(input word_t w, input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = w[31:24];
			2'd1:    r = w[23:16];
			2'd2:    r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

	logic [63:0] byte_total_q;
	logic [63:0] len_q;
	word_t       w_q [BLK_WORDS];
	word_t       w_d [BLK_WORDS];
	word_t       chain_q [CV_WORDS];
	word_t       digest_q [CV_WORDS];
	word_t       a_q, b_q, c_q, d_q, e_q;
	word_t       rest_word_q;
	logic [2:0]  rest_cnt_q;
	logic        last_q;
	logic        out_valid_q;

	logic [5:0]  pos;
	logic [2:0]  in_cnt;
	logic [6:0]  room;
	logic        in_fill;
	logic [2:0]  first_cnt;
	logic [2:0]  rest_cnt;
	word_t       rest_word;
	word_t       ins_word;
	logic [2:0]  ins_cnt;
	logic        ins_en;
	word_t       t_val;
	word_t       w_new;
	word_t       w_new_x;

	assign pos       = byte_total_q[5:0];
	assign in_cnt    = (valid_bytes > MAX_BYTES) ? MAX_BYTES : valid_bytes;
	assign room      = 7'(BLK_BYTES) - {1'b0, pos};
	assign in_fill   = ({4'd0, in_cnt} >= room);
	assign first_cnt = in_fill ? room[2:0] : in_cnt;
	assign rest_cnt  = in_cnt - first_cnt;
	assign rest_word = data_word << {first_cnt, 3'b000};

	assign ins_en   = (cmd.op == OP_INS_IN) || (cmd.op == OP_INS_REST);
	assign ins_word = (cmd.op == OP_INS_REST) ? rest_word_q : data_word;
	assign ins_cnt  = (cmd.op == OP_INS_REST) ? rest_cnt_q : first_cnt;

	assign t_val = {a_q[26:0], a_q[31:27]} + round_f(cmd.rnd, b_q, c_q, d_q) + e_q
		+ round_k(cmd.rnd) + w_q[0];
	assign w_new = {w_new_x[30:0], w_new_x[31]};

	assign w_new_x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];

	// next block buffer: byte insertion, padding, length, or schedule shift
	always_comb begin
		logic [6:0] jj;
		logic [6:0] off;
		jj  = '0;
		off = '0;
		w_d = w_q;
		case (cmd.op)
			OP_INS_IN, OP_INS_REST, OP_PAD: begin
				for (int j = 0; j < BLK_BYTES; j++) begin
					jj  = 7'(j);
					off = jj - {1'b0, pos};
					if (ins_en) begin
						if (jj >= {1'b0, pos} && off < {4'd0, ins_cnt}) begin
							w_d[j / 4][31 - 8 * (j % 4) -: 8] = pick_byte(ins_word, off[1:0]);
						end
					end else begin
						if (jj == {1'b0, pos}) begin
							w_d[j / 4][31 - 8 * (j % 4) -: 8] = PAD_BYTE;
						end else if (jj > {1'b0, pos}) begin
							w_d[j / 4][31 - 8 * (j % 4) -: 8] = 8'h00;
						end
					end
				end
			end
			OP_LEN, OP_LEN_ZERO: begin
				if (cmd.op == OP_LEN_ZERO) begin
					for (int i = 0; i < LEN_OFFSET / 4; i++) begin
						w_d[i] = '0;
					end
				end
				w_d[BLK_WORDS - 2] = len_q[63:32];
				w_d[BLK_WORDS - 1] = len_q[31:0];
			end
			OP_ROUND: begin
				for (int i = 0; i < BLK_WORDS - 1; i++) begin
					w_d[i] = w_q[i + 1];
				end
				w_d[BLK_WORDS - 1] = w_new;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		w_q <= w_d;
		case (cmd.op)
			OP_INIT: begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end
			OP_ROUND: begin
				a_q <= t_val;
				b_q <= a_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q;
				e_q <= d_q;
			end
			OP_INS_IN: begin
				rest_word_q <= rest_word;
				rest_cnt_q  <= rest_cnt;
			end
			OP_PAD:   len_q <= {byte_total_q[60:0], 3'b000};
			OP_FINAL: digest_q <= chain_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q      <= SHA_IV;
			byte_total_q <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_INS_IN: begin
					byte_total_q <= byte_total_q + 64'(first_cnt);
					last_q       <= last_word;
				end
				OP_INS_REST: byte_total_q <= byte_total_q + 64'(rest_cnt_q);
				OP_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
				end
				OP_FINAL: begin
					chain_q      <= SHA_IV;
					byte_total_q <= '0;
				end
				default: ;
			endcase
			if (cmd.op == OP_FINAL) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.in_fill  = in_fill;
	assign stat.in_last  = last_word;
	assign stat.last     = last_q;
	assign stat.pad_wrap = (pos >= 6'(LEN_OFFSET));
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign digest_h0 = digest_q[0];
	assign digest_h1 = digest_q[1];
	assign digest_h2 = digest_q[2];
	assign digest_h3 = digest_q[3];
	assign digest_h4 = digest_q[4];

	a_rest_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_INS_REST) |-> (pos == 6'd0))
		else $error("carried bytes not placed at the start of a block");

	a_final_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINAL) |-> (!out_valid_q || !out_stall))
		else $error("digest overwritten before delivery");

	a_final_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINAL) |=> (out_valid_q && byte_total_q == 64'd0))
		else $error("digest release did not take effect");

endmodule

@@ hw/rtl/sha1_hash_engine.sv @@
// Top level of the SHA-1 hash engine: sequencer plus datapath.
// The engine hashes a byte stream delivered as big-endian 32-bit words (first
// byte in bits 31:24); each item carries valid_bytes leading bytes (values
// above 4 count as 4) and last_word closes the message. A word that neither
// completes a 64-byte block nor closes the message is taken without a stall and
// the next item can follow at once. Each completed block stalls input while
// the engine loads the working variables, runs the 80 rounds through the
// single shared round unit (one round per cycle), folds the result into the
// chaining value, and writes any bytes of the filling word that spill past the
// block end (taken even when none spill). The last word adds a padding step, a
// length step and one compression (two compressions when fewer than 9 bytes of
// room remain in the block), then a load of the digest register. The digest
// stays on digest_h0..h4 with out_valid high until taken; input keeps flowing
// meanwhile, and only a second digest waits for the first to leave. After each
// digest the chaining value returns to the standard initial value and the byte
// count to zero.
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_h0,
	output logic [31:0] digest_h1,
	output logic [31:0] digest_h2,
	output logic [31:0] digest_h3,
	output logic [31:0] digest_h4
);
	import sha1_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: hold input while compressing, placing spilled bytes, padding or releasing a digest
	sha1_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: place bytes, advance the schedule, keep the digest register
	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_h0   (digest_h0),
		.digest_h1   (digest_h1),
		.digest_h2   (digest_h2),
		.digest_h3   (digest_h3),
		.digest_h4   (digest_h4)
	);

endmodule

@@ test/sha1_hash_engine_test.sv @@
// Self-checking testbench for sha1_hash_engine: directed and random messages against a built-in SHA-1 tracker.
module sha1_hash_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1_pkg::*;

	localparam int unsigned ITEM_TARGET  = 1650;
	localparam int unsigned IDLE_PCT     = 36;
	localparam int unsigned REPORT_LIMIT = 10;
	// Longest quiet spell allowed: above the receiver hold-off and a two-block finish.
	localparam int unsigned QUIET_LIMIT  = 20000;
	localparam int unsigned HOLD_CYCLES  = 4000;
	localparam int unsigned HOLD_AT      = 12;
	// Covers a two-block finish plus the digest load, with margin.
	localparam int unsigned TAIL_CYCLES  = 300;
	// Window of items sent with no idling on either side.
	localparam int unsigned CALM_FROM    = 600;
	localparam int unsigned CALM_TO      = 900;

	typedef logic [159:0] digest_t;

	// Tracks the message stream as the engine sees it and queues the digests it should emit.
	class digest_ledger;
		word_t       chain [CV_WORDS];
		word_t       block_buf [BLK_WORDS];
		logic [63:0] msg_bytes;
		digest_t     expected_q [$];
		int unsigned failures;

		function new();
			foreach (block_buf[i])
				block_buf[i] = '0;
			failures = 0;
			restart();
		endfunction

		function void restart();
			foreach (chain[i])
				chain[i] = SHA_IV[i];
			msg_bytes = '0;
		endfunction

		function word_t rol(input word_t x, input int unsigned n);
			return (x << n) | (x >> (32 - n));
		endfunction

		// Run the 80 rounds over the buffered block and fold into the chain.
		function void fold_block();
			word_t sched [80];
			word_t a, b, c, d, e, f, k, t_next;
			for (int t = 0; t < BLK_WORDS; t++)
				sched[t] = block_buf[t];
			for (int t = BLK_WORDS; t < 80; t++)
				sched[t] = rol(sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16], 1);
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int t = 0; t < 80; t++) begin
				if (t < 20) begin
					f = (b & c) | (~b & d);
					k = K_CH;
				end else if (t < 40) begin
					f = b ^ c ^ d;
					k = K_PA1;
				end else if (t < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K_MAJ;
				end else begin
					f = b ^ c ^ d;
					k = K_PA2;
				end
				t_next = rol(a, 5) + f + e + k + sched[t];
				e = d;
				d = c;
				c = rol(b, 30);
				b = a;
				a = t_next;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		function void append_byte(input logic [7:0] v);
			logic [5:0] pos;
			pos = msg_bytes[5:0];
			block_buf[pos[5:2]][8*(3 - pos[1:0]) +: 8] = v;
			msg_bytes++;
			if (msg_bytes[5:0] == 6'd0)
				fold_block();
		endfunction

		// Note one accepted input item; a closing item queues its digest.
		function void take_word(input word_t w, input logic [2:0] nb, input logic lw);
			int unsigned n;
			logic [63:0] bit_len;
			n = (nb > MAX_BYTES) ? MAX_BYTES : nb;
			for (int i = 0; i < n; i++)
				append_byte(w[31-8*i -: 8]);
			if (!lw)
				return;
			bit_len = msg_bytes << 3;
			append_byte(PAD_BYTE);
			while (msg_bytes[5:0] != LEN_OFFSET)
				append_byte(8'h00);
			for (int i = 0; i < 8; i++)
				append_byte(bit_len[63-8*i -: 8]);
			expected_q.push_back({chain[0], chain[1], chain[2], chain[3], chain[4]});
			restart();
		endfunction

		function void check_digest(input digest_t got);
			digest_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("digest %h arrived with none expected", got);
				return;
			end
			want = expected_q.pop_front();
			for (int i = 0; i < CV_WORDS; i++)
				if (want[159-32*i -: 32] !== got[159-32*i -: 32]) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("digest_h%0d mismatch: expected %h, got %h", i,
							want[159-32*i -: 32], got[159-32*i -: 32]);
				end
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] data_word = '0;
	logic [2:0]  valid_bytes = '0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_h0, digest_h1, digest_h2, digest_h3, digest_h4;

	digest_ledger ledger = new();
	int unsigned  items_sent = 0;
	int unsigned  digests_taken = 0;
	// High while neither side idles: the steady stretch of the run.
	bit           calm = 1'b0;

	sha1_hash_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last_word   (last_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_h0   (digest_h0),
		.digest_h1   (digest_h1),
		.digest_h2   (digest_h2),
		.digest_h3   (digest_h3),
		.digest_h4   (digest_h4)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bias data towards the all-zero and all-one words now and then.
	function automatic word_t pick_data();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// Offer one item, idling at random first, and hold it until the engine takes it.
	// Valid stays high on return so a back-to-back item needs no extra edge.
	task automatic send_word(input word_t w, input logic [2:0] nb, input logic lw);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		data_word   <= w;
		valid_bytes <= nb;
		last_word   <= lw;
		do
			@(posedge clk);
		while (in_stall);
		ledger.take_word(w, nb, lw);
		items_sent++;
	endtask

	// Send body_words items, then the closing item with last_nb bytes.
	// A ragged body mixes short and oversized byte counts into the middle of the message.
	task automatic send_message(input int unsigned body_words, input bit ragged,
			input logic [2:0] last_nb);
		for (int i = 0; i < body_words; i++)
			send_word(pick_data(), ragged ? 3'($urandom_range(7)) : MAX_BYTES, 1'b0);
		send_word(pick_data(), last_nb, 1'b1);
	endtask

	// Drop valid and hold off until every queued digest has come out.
	task automatic drain_digests();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (ledger.outstanding() != 0);
	endtask

	// Receiver: check each digest taken, stall at random, and once hold off for a long
	// stretch so that a second digest backs up and the engine stalls its input.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				ledger.check_digest({digest_h0, digest_h1, digest_h2, digest_h3, digest_h4});
				digests_taken++;
				if (digests_taken == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Watchdog: end the run if no item moves on either side for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned body;
		bit          ragged;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: the classic three-byte message.
		send_word(32'h61626300, 3'd3, 1'b1);
		// Empty message; the data bits must be ignored.
		send_word('1, 3'd0, 1'b1);
		// Oversized byte counts count as four, on the closing item and mid-message.
		send_word('1, 3'd7, 1'b1);
		send_word('0, 3'd5, 1'b0);
		send_word(32'hA5C3_0F96, 3'd6, 1'b1);
		// Partial words mid-message: later bytes continue at byte level.
		send_word(32'h8000_0001, 3'd1, 1'b0);
		send_word(32'h7FFF_FFFE, 3'd2, 1'b0);
		send_word(32'h1234_5678, 3'd3, 1'b1);
		// 56 bytes: no room for the length, so padding spills into a second block.
		send_message(13, 1'b0, MAX_BYTES);
		// Pause the sender until every digest so far is out.
		drain_digests();

		// Random messages: mostly well-formed, sized around the block boundaries.
		while (items_sent < ITEM_TARGET) begin
			calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
			case ($urandom_range(9))
				0, 1, 2, 3: body = $urandom_range(6);
				4, 5:       body = $urandom_range(17, 12);
				6:          body = $urandom_range(33, 28);
				7, 8:       body = $urandom_range(20);
				default:    body = $urandom_range(48);
			endcase
			ragged = ($urandom_range(9) == 0);
			send_message(body, ragged,
				ragged ? 3'($urandom_range(7)) : 3'($urandom_range(4)));
			// Pause again after each message that ends in a window late in the run, so the engine runs dry between messages.
			if (items_sent >= 1200 && items_sent < 1240)
				drain_digests();
		end
		calm = 1'b0;

		drain_digests();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.failures == 0 && ledger.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

@@ sim.f @@
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_ctrl.sv
hw/rtl/sha1_dp.sv
hw/rtl/sha1_hash_engine.sv
test/sha1_hash_engine_test.sv
